// ----- rtl/diff_drive_odometry_defines.svh -----
// assertion helpers for the odometry block
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ODO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, checked outside reset
`define ODO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- rtl/odo_pkg.sv -----
`default_nettype none
package odo_pkg;

	// cordic iteration count and counter width
	localparam int CORDIC_STEPS = 24;
	localparam int ITER_W = $clog2(CORDIC_STEPS);

	// cordic start magnitude, 0.60725 at unit 2^30
	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

	// blend weight of one, Q1.16
	localparam logic [16:0] W_ONE = 17'd65536;

	// register indexes
	localparam logic [1:0] REG_LIN = 2'd0;
	localparam logic [1:0] REG_ANG = 2'd1;
	localparam logic [1:0] REG_GYRO = 2'd2;
	localparam logic [1:0] REG_WEIGHT = 2'd3;

	// multiply operations in issue order
	typedef enum logic [3:0] {
		OP_DIST,
		OP_ENC,
		OP_GYR,
		OP_WLO,
		OP_WHI,
		OP_CLO,
		OP_CHI,
		OP_SLO,
		OP_SHI
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	// cordic result bundle
	typedef struct packed {
		logic               done;
		logic signed [25:0] cos_v;
		logic signed [25:0] sin_v;
	} cordic_res_t;

	// arctangent table in binary angle units
	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			5'd31: v = 32'h00000000;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/odo_cordic.sv -----
`default_nettype none
module odo_cordic
	import odo_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] angle,
	output cordic_res_t      res
);

	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [ITER_W-1:0]  iter_q;
	logic               busy_q, done_q, flip_q;

	logic signed [32:0] z_in, z_alt;
	logic               need_flip;
	logic signed [33:0] xs, ys, xf, yf;
	logic signed [32:0] at;

	// fold angles outside the right half plane
	assign z_in      = 33'(signed'(angle));
	assign z_alt     = 33'(signed'(angle ^ 32'h80000000));
	assign need_flip = (z_in > 33'sd1073741824) || (z_in < -33'sd1073741824);

	// one rotation step per cycle
	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign at = 33'(atan_lut(5'(iter_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (busy_q) begin
			if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	// rotation datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_K;
			y_q    <= '0;
			z_q    <= need_flip ? z_alt : z_in;
			flip_q <= need_flip;
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	// undo the fold and scale to unit 2^22
	assign xf = flip_q ? -x_q : x_q;
	assign yf = flip_q ? -y_q : y_q;

	assign res.done  = done_q;
	assign res.cos_v = 26'(xf >>> 8);
	assign res.sin_v = 26'(yf >>> 8);

endmodule
`default_nettype wire

// ----- rtl/odo_mul.sv -----
`default_nettype none
module odo_mul
	import odo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [26:0] a,
	input  wire logic signed [23:0] b,
	output logic signed [50:0]      prod_q
);

	// shared signed multiplier, registered product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 51'(a) * 51'(b);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/diff_drive_odometry.sv -----
// channel   dir  fields (low bit up)                        handshake
// s_axis    in   left_rpm, right_rpm, gyro_rate (48 bits)   s_tvalid / s_tready
// m_axis    out  pose_x, pose_y, heading (96 bits)          m_tvalid / m_tready
// apb       in   lin_gain, ang_gain, gyro_gain, fusion_weight at 0x0, 0x4, 0x8, 0xc
//
// a word is taken only in idle, and the next word only once its result has gone to the
// output register: the cordic rotates the heading while the shared 27x24 multiplier
// runs nine products in turn, the last four waiting for the cordic.
// arst_n clears pose, heading, gain registers and control and sets the weight to 64225; no clearing pass.
// a result waits in the output register while the next word is taken.
`default_nettype none
`include "diff_drive_odometry_defines.svh"
module diff_drive_odometry
	import odo_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // left_rpm, right_rpm, gyro_rate
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,   // pose_x, pose_y, heading
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	state_t state_q, state_d;
	op_t    op_q;

	logic [23:0] lin_gain_q, ang_gain_q, gyro_gain_q;
	logic [16:0] weight_q, w_eff;

	logic signed [16:0] sum_q, diff_q;
	logic signed [15:0] gyro_q;
	logic signed [40:0] dist_q;
	logic signed [41:0] enc_q;
	logic signed [42:0] eg_q;
	logic signed [67:0] acc_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [31:0]        head_q;
	logic [95:0]        out_q;
	logic               out_valid_q;

	logic               accept, mul_en, acc_en, load_out, needs_cordic;
	logic signed [26:0] a_op;
	logic signed [23:0] b_op;
	logic signed [50:0] prod_q;
	logic signed [67:0] pext, pos_sum;
	logic [47:0]        hsum;
	logic signed [32:0] new_pos;
	logic signed [31:0] cur_pos, sat_pos;
	cordic_res_t        cres;

	// configuration port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q  <= '0;
			ang_gain_q  <= '0;
			gyro_gain_q <= '0;
			weight_q    <= 17'd64225;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_LIN:    lin_gain_q  <= pwdata[23:0];
				REG_ANG:    ang_gain_q  <= pwdata[23:0];
				REG_GYRO:   gyro_gain_q <= pwdata[23:0];
				REG_WEIGHT: weight_q    <= pwdata[16:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LIN:    prdata = {8'd0, lin_gain_q};
			REG_ANG:    prdata = {8'd0, ang_gain_q};
			REG_GYRO:   prdata = {8'd0, gyro_gain_q};
			REG_WEIGHT: prdata = {15'd0, weight_q};
			default:    prdata = '0;
		endcase
	end

	assign w_eff = (weight_q > W_ONE) ? W_ONE : weight_q;

	// shared units
	odo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.angle  (head_q),
		.res    (cres)
	);

	odo_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (a_op),
		.b      (b_op),
		.prod_q (prod_q)
	);

	assign needs_cordic = (op_q == OP_CLO) || (op_q == OP_CHI) ||
		(op_q == OP_SLO) || (op_q == OP_SHI);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_MUL;
			ST_MUL:  if (!needs_cordic || cres.done) state_d = ST_ACC;
			ST_ACC:  state_d = (op_q == OP_SHI) ? ST_DONE : ST_MUL;
			ST_DONE: if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		mul_en   = 1'b0;
		acc_en   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL:  mul_en   = !needs_cordic || cres.done;
			ST_ACC:  acc_en   = 1'b1;
			ST_DONE: load_out = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_DIST;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= OP_DIST;
			end else if (acc_en && op_q != OP_SHI) begin
				op_q <= op_t'(op_q + 4'd1);
			end
		end
	end

	// multiplier operand select
	always_comb begin
		unique case (op_q)
			OP_DIST: begin a_op = 27'({1'b0, lin_gain_q});  b_op = 24'(sum_q);  end
			OP_ENC:  begin a_op = 27'({1'b0, ang_gain_q});  b_op = 24'(diff_q); end
			OP_GYR:  begin a_op = 27'({1'b0, gyro_gain_q}); b_op = 24'(gyro_q); end
			OP_WLO:  begin a_op = 27'({1'b0, w_eff}); b_op = {2'b00, eg_q[21:0]}; end
			OP_WHI:  begin a_op = 27'({1'b0, w_eff}); b_op = 24'(signed'(eg_q[42:22])); end
			OP_CLO:  begin a_op = 27'(cres.cos_v); b_op = {2'b00, dist_q[21:0]}; end
			OP_CHI:  begin a_op = 27'(cres.cos_v); b_op = 24'(signed'(dist_q[40:22])); end
			OP_SLO:  begin a_op = 27'(cres.sin_v); b_op = {2'b00, dist_q[21:0]}; end
			OP_SHI:  begin a_op = 27'(cres.sin_v); b_op = 24'(signed'(dist_q[40:22])); end
			default: begin a_op = '0; b_op = '0; end
		endcase
	end

	// accumulate and saturate
	assign pext    = 68'(prod_q);
	assign hsum    = acc_q[47:0] + 48'(pext <<< 22);
	assign pos_sum = acc_q + (pext <<< 22);
	assign cur_pos = (op_q == OP_CHI) ? pos_x_q : pos_y_q;
	assign new_pos = 33'(cur_pos) + 33'(signed'(pos_sum[67:38]));
	assign sat_pos = (new_pos[32] != new_pos[31]) ?
		(new_pos[32] ? 32'sh80000000 : 32'sh7fffffff) : new_pos[31:0];

	// pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q  <= '0;
		end else if (acc_en) begin
			unique case (op_q)
				OP_GYR:  head_q  <= head_q + prod_q[31:0];
				OP_WHI:  head_q  <= head_q + hsum[47:16];
				OP_CHI:  pos_x_q <= sat_pos;
				OP_SHI:  pos_y_q <= sat_pos;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q  <= 17'(signed'(s_tdata[31:16])) + 17'(signed'(s_tdata[15:0]));
			diff_q <= 17'(signed'(s_tdata[31:16])) - 17'(signed'(s_tdata[15:0]));
			gyro_q <= s_tdata[47:32];
		end
		if (acc_en) begin
			unique case (op_q)
				OP_DIST: dist_q <= prod_q[40:0];
				OP_ENC:  enc_q  <= prod_q[41:0];
				OP_GYR:  eg_q   <= 43'(enc_q) - 43'(prod_q);
				OP_WLO:  acc_q  <= pext;
				OP_CLO:  acc_q  <= pext;
				OP_SLO:  acc_q  <= pext;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= {head_q, pos_y_q, pos_x_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// checks
	`ODO_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "input taken while busy")
	`ODO_ASSERT_NOW(a_cordic_ready, acc_en && needs_cordic, cres.done, "cordic used early")
	`ODO_ASSERT_NOW(a_done_only_after_start, $fell(cres.done), $past(accept), "cordic done lost")

endmodule
`default_nettype wire
